@@ design/wsq_pkg.sv @@
// shared types and constants for the square trajectory sequencer
// no dependencies; compiled first

package wsq_pkg;

  localparam int CoordW     = 11;
  localparam int NumCorners = 4;
  localparam int CfgIdxW    = 3;
  localparam int SegW       = 3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t pan;
    coord_t tilt;
  } point_t;

  // corner order: top left, top right, bottom right, bottom left
  localparam point_t CornerReset [NumCorners] = '{
    '{pan:  11'sd366, tilt: -11'sd472},
    '{pan: -11'sd416, tilt: -11'sd520},
    '{pan: -11'sd436, tilt:  11'sd414},
    '{pan:  11'sd405, tilt:  11'sd408}
  };

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_STOP = 3'b100
  } state_e;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  localparam logic [SegW-1:0] SEG_APPROACH  = 3'd0;
  localparam logic [SegW-1:0] SEG_LAST_EDGE = 3'd4;
  localparam logic [SegW-1:0] SEG_RETURN    = 3'd5;
  localparam logic [SegW-1:0] SEG_DONE      = 3'd6;

  localparam logic [1:0] CORNER_TL = 2'd0;

  localparam logic AXIS_PAN  = 1'b0;
  localparam logic AXIS_TILT = 1'b1;

endpackage

@@ design/wsq_in_if.sv @@
// input channel of the square trajectory sequencer: valid/ready plus item fields
// depends on wsq_pkg

interface wsq_in_if;
  import wsq_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       laser_fault;
  logic       servo_fault;
  logic       position_read_fault;
  coord_t     reported_pan;
  coord_t     reported_tilt;

  modport source (
    output valid, op, laser_fault, servo_fault, position_read_fault,
    output reported_pan, reported_tilt,
    input  ready
  );

  modport sink (
    input  valid, op, laser_fault, servo_fault, position_read_fault,
    input  reported_pan, reported_tilt,
    output ready
  );
endinterface

@@ design/wsq_out_if.sv @@
// result channel of the square trajectory sequencer: valid/ready plus result fields
// depends on wsq_pkg

interface wsq_out_if;
  import wsq_pkg::*;

  logic       valid;
  logic       ready;
  logic       command_valid;
  coord_t     command_pan;
  coord_t     command_tilt;
  logic       laser_enable;
  logic [1:0] run_mode;
  logic [2:0] segment_index;

  modport source (
    output valid, command_valid, command_pan, command_tilt,
    output laser_enable, run_mode, segment_index,
    input  ready
  );

  modport sink (
    input  valid, command_valid, command_pan, command_tilt,
    input  laser_enable, run_mode, segment_index,
    output ready
  );
endinterface

@@ design/wsq_scale.sv @@
// one axis of the interpolator: start + (delta * step) / segment length,
// quotient truncated toward zero, division by reciprocal multiply
// depends on wsq_pkg

module wsq_scale #(
  parameter int ProdW        = 22,
  parameter int MagW         = 20,
  parameter int EdgeSteps    = 200,
  parameter int TransitSteps = 100
) (
  input  logic signed [ProdW-1:0] prod_i,
  input  wsq_pkg::coord_t         start_i,
  input  logic                    transit_i,
  output wsq_pkg::coord_t         cmd_o
);
  import wsq_pkg::*;

  // ceil reciprocal with shift MagW + clog2(len) is exact for any magnitude below 2^MagW
  localparam int RecW      = MagW + 2;
  localparam int ScaledW   = MagW + RecW;
  localparam int EdgeSh    = MagW + $clog2(EdgeSteps);
  localparam int TransitSh = MagW + $clog2(TransitSteps);
  localparam logic [RecW-1:0] EdgeRec =
    RecW'(((64'd1 << EdgeSh) + 64'(EdgeSteps) - 64'd1) / 64'(EdgeSteps));
  localparam logic [RecW-1:0] TransitRec =
    RecW'(((64'd1 << TransitSh) + 64'(TransitSteps) - 64'd1) / 64'(TransitSteps));

  logic                    neg;
  logic signed [ProdW-1:0] abs_prod;
  logic [MagW-1:0]         mag;
  logic [RecW-1:0]         rec;
  logic [ScaledW-1:0]      scaled;
  logic [ScaledW-1:0]      shifted;
  logic [CoordW-1:0]       quot;
  logic [CoordW-1:0]       offset;

  always_comb begin
    neg      = prod_i[ProdW-1];
    abs_prod = neg ? -prod_i : prod_i;
    mag      = abs_prod[MagW-1:0];
    rec      = transit_i ? TransitRec : EdgeRec;
    scaled   = ScaledW'(mag) * ScaledW'(rec);
    shifted  = transit_i ? (scaled >> TransitSh) : (scaled >> EdgeSh);
    // quotient magnitude never exceeds the coordinate range, low bits suffice
    quot     = shifted[CoordW-1:0];
    offset   = neg ? (~quot + 1'b1) : quot;
    cmd_o    = coord_t'(start_i + offset);
  end

endmodule

@@ design/waypoint_square_trajectory_sequencer_core.sv @@
// Square trajectory sequencer for a pan/tilt laser head.
// Input channel in_i takes one item per transaction (tick, start, stop plus
// fault flags and the reported servo position); output channel out_o returns
// exactly one result per item: command point, laser state, run mode, segment.
// Corner points are written through cfg_we_i / cfg_idx_i / cfg_data_i, one
// coordinate per write; the user must write them only while no item is in
// flight, as the block itself does not enforce it. Sequencer state is updated
// in the cycle an item is accepted; the product delta * step is registered,
// then a reciprocal multiply per axis forms the command into the output
// register. Throughput: one item per cycle while out_o.ready stays high, set by
// the two-stage pipeline of multipliers.
// Reset: idle mode, segment 0, laser off, corners at their default square,
// both pipeline stages empty.
// When the receiver stalls, results back up into the pipeline register and
// in_i.ready falls only once both stages hold an item; nothing is dropped.
// Depends on wsq_pkg, wsq_in_if, wsq_out_if and wsq_scale.

module waypoint_square_trajectory_sequencer_core #(
  parameter int EDGE_STEPS    = 200,
  parameter int TRANSIT_STEPS = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wsq_in_if.sink                            in_i,
  wsq_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [wsq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wsq_pkg::coord_t                   cfg_data_i
);
  import wsq_pkg::*;

  localparam int MaxSteps = (EDGE_STEPS > TRANSIT_STEPS) ? EDGE_STEPS : TRANSIT_STEPS;
  localparam int StepW    = $clog2(MaxSteps + 1);
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = DiffW + StepW + 1;
  localparam int MagW     = CoordW + StepW;
  localparam logic [StepW-1:0] EdgeLen    = StepW'(EDGE_STEPS);
  localparam logic [StepW-1:0] TransitLen = StepW'(TRANSIT_STEPS);

  // sequencer state
  state_e            state_q, state_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [StepW-1:0]  step_q, step_d;
  coord_t            start_pan_q, start_pan_d;
  coord_t            start_tilt_q, start_tilt_d;
  logic              laser_q, laser_d;
  point_t            corner_q [NumCorners];

  // first pipeline stage
  logic                    s1_valid_q;
  logic                    s1_cmd_valid_q, s1_cmd_valid_d;
  logic signed [ProdW-1:0] s1_prod_pan_q, s1_prod_pan_d;
  logic signed [ProdW-1:0] s1_prod_tilt_q, s1_prod_tilt_d;
  coord_t                  s1_start_pan_q, s1_start_pan_d;
  coord_t                  s1_start_tilt_q, s1_start_tilt_d;
  logic                    s1_transit_q;
  logic                    s1_laser_q;
  logic [1:0]              s1_mode_q, s1_mode_d;
  logic [SegW-1:0]         s1_seg_q;

  // output register
  logic       out_valid_q;
  logic       out_cmd_valid_q;
  coord_t     out_pan_q;
  coord_t     out_tilt_q;
  logic       out_laser_q;
  logic [1:0] out_mode_q;
  logic [2:0] out_seg_q;

  logic                    out_ready;
  logic                    accept;
  logic                    s1_advance;
  logic                    seg_transit;
  logic [StepW-1:0]        seg_len;
  logic [StepW-1:0]        step_inc;
  logic [1:0]              corner_sel;
  point_t                  end_pt;
  logic signed [DiffW-1:0] diff_pan;
  logic signed [DiffW-1:0] diff_tilt;
  logic signed [ProdW-1:0] prod_pan;
  logic signed [ProdW-1:0] prod_tilt;
  logic                    safe;
  logic                    calc;
  coord_t                  cmd_pan;
  coord_t                  cmd_tilt;

  assign out_ready  = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign s1_advance = s1_valid_q && out_ready;

  // segment geometry
  always_comb begin
    seg_transit = (seg_q == SEG_APPROACH) || (seg_q == SEG_RETURN);
    seg_len     = seg_transit ? TransitLen : EdgeLen;
    step_inc    = (step_q < seg_len) ? step_q + 1'b1 : step_q;
    corner_sel  = (seg_q == SEG_LAST_EDGE) ? CORNER_TL : seg_q[1:0];
    end_pt      = (seg_q == SEG_RETURN) ? '0 : corner_q[corner_sel];
    diff_pan    = DiffW'(end_pt.pan) - DiffW'(start_pan_q);
    diff_tilt   = DiffW'(end_pt.tilt) - DiffW'(start_tilt_q);
    prod_pan    = ProdW'(diff_pan) * ProdW'($signed({1'b0, step_inc}));
    prod_tilt   = ProdW'(diff_tilt) * ProdW'($signed({1'b0, step_inc}));
  end

  // item decode and state update
  always_comb begin
    state_d        = state_q;
    seg_d          = seg_q;
    step_d         = step_q;
    start_pan_d    = start_pan_q;
    start_tilt_d   = start_tilt_q;
    laser_d        = laser_q;
    s1_cmd_valid_d = 1'b0;
    safe           = 1'b0;
    calc           = 1'b0;

    case (in_i.op)
      OP_START: begin
        laser_d = 1'b0;
        seg_d   = '0;
        step_d  = '0;
        if (in_i.position_read_fault) begin
          safe = 1'b1;
        end else begin
          start_pan_d  = in_i.reported_pan;
          start_tilt_d = in_i.reported_tilt;
          state_d      = ST_RUN;
        end
      end
      OP_STOP: begin
        safe = 1'b1;
      end
      OP_TICK: begin
        unique case (state_q) inside
          ST_RUN: begin
            if (in_i.laser_fault) begin
              safe = 1'b1;
            end else if (seg_q >= SEG_DONE) begin
              laser_d        = 1'b0;
              s1_cmd_valid_d = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              step_d         = step_inc;
              s1_cmd_valid_d = 1'b1;
              calc           = 1'b1;
              if (in_i.servo_fault) begin
                safe = 1'b1;
              end else if (step_inc >= seg_len) begin
                if (seg_q == SEG_APPROACH) begin
                  laser_d = 1'b1;
                end else if (seg_q == SEG_LAST_EDGE) begin
                  laser_d = 1'b0;
                end
                seg_d = seg_q + 1'b1;
                if (seg_q == SEG_RETURN) begin
                  laser_d = 1'b0;
                  state_d = ST_IDLE;
                end else if (in_i.position_read_fault) begin
                  safe = 1'b1;
                end else begin
                  start_pan_d  = in_i.reported_pan;
                  start_tilt_d = in_i.reported_tilt;
                  step_d       = '0;
                end
              end
            end
          end
          ST_IDLE, ST_STOP: begin
          end
          default: begin
            safe = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase

    if (safe) begin
      laser_d        = 1'b0;
      state_d        = ST_STOP;
      s1_cmd_valid_d = 1'b1;
      calc           = 1'b0;
    end

    // a zero product from a zero start gives the centre / blank command
    s1_prod_pan_d   = calc ? prod_pan : '0;
    s1_prod_tilt_d  = calc ? prod_tilt : '0;
    s1_start_pan_d  = calc ? start_pan_q : '0;
    s1_start_tilt_d = calc ? start_tilt_q : '0;

    unique case (state_d)
      ST_RUN:  s1_mode_d = MODE_RUN;
      ST_STOP: s1_mode_d = MODE_STOP;
      default: s1_mode_d = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seg_q        <= '0;
      step_q       <= '0;
      start_pan_q  <= '0;
      start_tilt_q <= '0;
      laser_q      <= 1'b0;
    end else if (accept) begin
      state_q      <= state_d;
      seg_q        <= seg_d;
      step_q       <= step_d;
      start_pan_q  <= start_pan_d;
      start_tilt_q <= start_tilt_d;
      laser_q      <= laser_d;
    end
  end

  // corner registers: index bits [2:1] pick the corner, bit 0 the axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= CornerReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0] == AXIS_TILT) begin
        corner_q[cfg_idx_i[2:1]].tilt <= cfg_data_i;
      end else begin
        corner_q[cfg_idx_i[2:1]].pan <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_valid_q  <= s1_cmd_valid_d;
      s1_prod_pan_q   <= s1_prod_pan_d;
      s1_prod_tilt_q  <= s1_prod_tilt_d;
      s1_start_pan_q  <= s1_start_pan_d;
      s1_start_tilt_q <= s1_start_tilt_d;
      s1_transit_q    <= seg_transit;
      s1_laser_q      <= laser_d;
      s1_mode_q       <= s1_mode_d;
      s1_seg_q        <= seg_d;
    end
  end

  wsq_scale #(
    .ProdW        (ProdW),
    .MagW         (MagW),
    .EdgeSteps    (EDGE_STEPS),
    .TransitSteps (TRANSIT_STEPS)
  ) u_scale_pan (
    .prod_i    (s1_prod_pan_q),
    .start_i   (s1_start_pan_q),
    .transit_i (s1_transit_q),
    .cmd_o     (cmd_pan)
  );

  wsq_scale #(
    .ProdW        (ProdW),
    .MagW         (MagW),
    .EdgeSteps    (EDGE_STEPS),
    .TransitSteps (TRANSIT_STEPS)
  ) u_scale_tilt (
    .prod_i    (s1_prod_tilt_q),
    .start_i   (s1_start_tilt_q),
    .transit_i (s1_transit_q),
    .cmd_o     (cmd_tilt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_cmd_valid_q <= s1_cmd_valid_q;
      out_pan_q       <= cmd_pan;
      out_tilt_q      <= cmd_tilt;
      out_laser_q     <= s1_laser_q;
      out_mode_q      <= s1_mode_q;
      out_seg_q       <= s1_seg_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.command_valid = out_cmd_valid_q;
  assign out_o.command_pan   = out_pan_q;
  assign out_o.command_tilt  = out_tilt_q;
  assign out_o.laser_enable  = out_laser_q;
  assign out_o.run_mode      = out_mode_q;
  assign out_o.segment_index = out_seg_q;

endmodule
